// File: hdl/lpht_pkg.sv
// Shared types, codes and defaults for the linear-probe hash table.
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

  // Default table geometry
  localparam int SLOTS_DEF    = 128;
  localparam int KEY_BITS_DEF = 16;

  // Fixed field widths of the item ports
  localparam int KEY_W    = 16;
  localparam int VAL_W    = 16;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 7;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PRIME,
    S_PROBE,
    S_FINISH
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic clr;     // write one empty entry of the clearing pass
    logic load;    // capture the incoming item
    logic hash;    // one home-slot remainder step
    logic prime;   // read the home slot
    logic probe;   // check one slot, read the next
    logic finish;  // move the result into the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_done;
    logic hash_done;
    logic probe_stop;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: hdl/linear_probe_hash_table.sv
// Linear-probe hash table top level: insert and search items over valid/ready channels.
// Sequence: after accept, a product step and a remainder step find the home slot, then the
//   home slot is read and the walk examines 1..SLOTS slots, one RAM read a cycle.
// Items: one at a time; the next is taken only once the result has reached the output register.
// Reset: a clearing pass marks every slot empty; no item is taken until it ends.
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_table #(
  parameter int SLOTS    = lpht_pkg::SLOTS_DEF,
  parameter int KEY_BITS = lpht_pkg::KEY_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          operation_i,
  input  wire logic [lpht_pkg::KEY_W-1:0]    key_i,
  input  wire logic [lpht_pkg::VAL_W-1:0]    value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [lpht_pkg::STATUS_W-1:0] status_o,
  output logic      [lpht_pkg::VAL_W-1:0]    found_value_o,
  output logic      [lpht_pkg::SLOT_W-1:0]   slot_o
);
  import lpht_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  lpht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Table and probe datapath
  lpht_datapath #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .operation_i   (operation_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .found_value_o (found_value_o),
    .slot_o        (slot_o)
  );

endmodule

`default_nettype wire

// File: hdl/lpht_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/lpht_datapath.sv
// Datapath: item capture, home-slot remainder, probe walk, table RAM, result register.
`timescale 1ns / 1ps
`default_nettype none

module lpht_datapath #(
  parameter int SLOTS    = lpht_pkg::SLOTS_DEF,
  parameter int KEY_BITS = lpht_pkg::KEY_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lpht_pkg::cmd_t                cmd_i,
  output lpht_pkg::sts_t                     sts_o,
  input  wire logic                          operation_i,
  input  wire logic [lpht_pkg::KEY_W-1:0]    key_i,
  input  wire logic [lpht_pkg::VAL_W-1:0]    value_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic      [lpht_pkg::STATUS_W-1:0] status_o,
  output logic      [lpht_pkg::VAL_W-1:0]    found_value_o,
  output logic      [lpht_pkg::SLOT_W-1:0]   slot_o
);
  import lpht_pkg::*;

  localparam int IW     = $clog2(SLOTS);
  localparam int KW     = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int WORD_W = 1 + KW + VAL_W;
  localparam int SH_W   = KW + IW;
  localparam int PROD_W = SH_W + KW;
  localparam int REM_W  = KW + IW;
  localparam int RCP_W  = KW + 2;

  localparam logic [IW:0]   SLOTS_W   = (IW+1)'(SLOTS);
  localparam logic [IW-1:0] LAST_IDX  = IW'(SLOTS - 1);
  // Rounded-up reciprocal of the slot count, exact quotient for every key
  localparam logic [RCP_W-1:0] RECIP  =
    RCP_W'(((64'd1 << SH_W) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));

  // Step an index forward, wrapping after the last slot
  function automatic logic [IW-1:0] wrap_idx(input logic [IW-1:0] a);
    return (a == LAST_IDX) ? '0 : a + 1'b1;
  endfunction

  // Item registers
  logic              op_q;
  logic [KW-1:0]     key_q;
  logic [VAL_W-1:0]  val_q;

  // Remainder unit
  logic              hstep_q;
  logic [PROD_W-1:0] prod_q;
  logic [KW-1:0]     quot;
  logic [REM_W-1:0]  rem_full;
  logic [IW-1:0]     rem_q;

  // Probe walk
  logic [IW-1:0]     rd_addr_q;
  logic [IW-1:0]     chk_addr_q;
  logic [IW-1:0]     chk_cnt_q;
  logic [IW-1:0]     clr_addr_q;

  // Table access
  logic [WORD_W-1:0] rd_word;
  logic              ent_valid;
  logic [KW-1:0]     ent_key;
  logic [VAL_W-1:0]  ent_val;
  logic              is_search;
  logic              empty;
  logic              match;
  logic              last;
  logic              stop;
  logic              ins_wr;
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IW-1:0]     ram_raddr;

  // Result and output registers
  status_e           res_status;
  logic [VAL_W-1:0]  res_val;
  status_e           res_status_q;
  logic [VAL_W-1:0]  res_val_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic [SLOT_W+IW-1:0] slot_wide;
  logic              out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [VAL_W-1:0]  out_val_q;
  logic [SLOT_W-1:0] out_slot_q;

  // Capture the item, keep only the key bits in use
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= operation_i;
      key_q <= key_i[KW-1:0];
      val_q <= value_i;
    end
  end

  // Home slot by reciprocal multiply: product first, then key minus quotient times slots
  assign quot     = prod_q[PROD_W-1:SH_W];
  assign rem_full = REM_W'(key_q) - REM_W'(quot) * REM_W'(SLOTS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hstep_q <= 1'b0;
    end else if (cmd_i.hash) begin
      hstep_q <= 1'b1;
      if (!hstep_q) begin
        prod_q <= PROD_W'(key_q) * PROD_W'(RECIP);
      end else begin
        rem_q <= rem_full[IW-1:0];
      end
    end
  end

  // Decode the entry read for the slot under check
  assign ent_valid = rd_word[WORD_W-1];
  assign ent_key   = rd_word[VAL_W +: KW];
  assign ent_val   = rd_word[VAL_W-1:0];
  assign is_search = (op_q == OP_SEARCH);
  assign empty     = !ent_valid;
  assign match     = is_search && ent_valid && (ent_key == key_q);
  assign last      = (chk_cnt_q == LAST_IDX);
  assign stop      = empty || match || last;
  assign ins_wr    = cmd_i.probe && empty && !is_search;

  // Pick the outcome of the current check
  always_comb begin
    res_val = '0;
    if (empty) begin
      res_status = is_search ? ST_NOT_FOUND : ST_INSERTED;
    end else if (match) begin
      res_status = ST_FOUND;
      res_val    = ent_val;
    end else begin
      res_status = is_search ? ST_NOT_FOUND : ST_FULL;
    end
  end

  assign slot_wide = {{SLOT_W{1'b0}}, chk_addr_q};

  // Walk the probe sequence with one read in flight
  always_ff @(posedge clk_i) begin
    if (cmd_i.prime) begin
      chk_addr_q <= rem_q;
      rd_addr_q  <= wrap_idx(rem_q);
      chk_cnt_q  <= '0;
    end else if (cmd_i.probe && !stop) begin
      chk_addr_q <= rd_addr_q;
      rd_addr_q  <= wrap_idx(rd_addr_q);
      chk_cnt_q  <= chk_cnt_q + 1'b1;
    end
  end

  // Latch the result when the walk stops
  always_ff @(posedge clk_i) begin
    if (cmd_i.probe && stop) begin
      res_status_q <= res_status;
      res_val_q    <= res_val;
      res_slot_q   <= (res_status == ST_INSERTED || res_status == ST_FOUND) ?
                      slot_wide[SLOT_W-1:0] : '0;
    end
  end

  // Advance the clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_addr_q <= wrap_idx(clr_addr_q);
    end
  end

  // Table RAM port muxing
  assign ram_we    = cmd_i.clr || ins_wr;
  assign ram_waddr = cmd_i.clr ? clr_addr_q : chk_addr_q;
  assign ram_wdata = cmd_i.clr ? '0 : {1'b1, key_q, val_q};
  assign ram_re    = cmd_i.prime || (cmd_i.probe && !stop);
  assign ram_raddr = cmd_i.prime ? rem_q : rd_addr_q;

  lpht_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_word)
  );

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_status_q <= res_status_q;
      out_val_q    <= res_val_q;
      out_slot_q   <= res_slot_q;
    end
  end

  assign sts_o.clr_done   = (clr_addr_q == LAST_IDX);
  assign sts_o.hash_done  = hstep_q;
  assign sts_o.probe_stop = stop;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_value_o = out_val_q;
  assign slot_o        = out_slot_q;

  // The home slot stays inside the table
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.prime |-> ({1'b0, rem_q} < SLOTS_W))
    else $error("home slot out of range");

  // A result other than found carries a zero value
  a_val_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q != ST_FOUND) |-> (out_val_q == '0))
    else $error("nonzero value on a miss");

  // A waiting result holds until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_status_q) &&
      $stable(out_val_q) && $stable(out_slot_q))
    else $error("waiting result changed");

endmodule

`default_nettype wire

// File: hdl/lpht_ctrl.sv
// Controller: state machine sequencing clear, hash, probe and result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module lpht_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire lpht_pkg::sts_t sts_i,
  output lpht_pkg::cmd_t      cmd_o
);
  import lpht_pkg::*;

  state_e state_q;
  state_e state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_HASH;
        end
      end
      S_HASH: begin
        cmd_o.hash = 1'b1;
        if (sts_i.hash_done) begin
          state_d = S_PRIME;
        end
      end
      S_PRIME: begin
        cmd_o.prime = 1'b1;
        state_d     = S_PROBE;
      end
      S_PROBE: begin
        cmd_o.probe = 1'b1;
        if (sts_i.probe_stop) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // At most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.clr, cmd_o.load, cmd_o.hash, cmd_o.prime, cmd_o.probe, cmd_o.finish}))
    else $error("overlapping datapath commands");

  // An accepted item goes straight into the remainder steps
  a_load_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_HASH))
    else $error("item load not followed by hash");

  // Never overwrite a result still waiting downstream
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> sts_i.out_free)
    else $error("result overwritten");

endmodule

`default_nettype wire
